FILE: hw/rtl/see_pkg.sv
package see_pkg;

  localparam int SEE_STACK_DEPTH   = 16;
  localparam int SEE_FRACTION_BITS = 16;

  // token commands
  localparam logic [2:0] CMD_PUSH = 3'd0;
  localparam logic [2:0] CMD_ADD  = 3'd1;
  localparam logic [2:0] CMD_SUB  = 3'd2;
  localparam logic [2:0] CMD_MUL  = 3'd3;
  localparam logic [2:0] CMD_DIV  = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_DIV0  = 3'd1;
  localparam logic [2:0] ST_UNDER = 3'd2;
  localparam logic [2:0] ST_OVER  = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] operand_value;
    logic               last_token;
  } see_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic [2:0]         status;
  } see_out_t;

  // per-cell shift control
  typedef struct packed {
    logic shift_dn;  // take the word from the cell above (push side)
    logic shift_up;  // take the word from the cell below (pop side)
  } see_shift_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT,
    S_FIN
  } see_state_t;

  typedef enum logic [2:0] {
    ALU_IDLE,
    ALU_MUL,
    ALU_DIV_CHK,
    ALU_DIV_RUN,
    ALU_DIV_FIX,
    ALU_DONE
  } see_alu_state_t;

endpackage

FILE: hw/rtl/see_cell.sv
module see_cell (
  input  logic                clk,
  input  see_pkg::see_shift_t ctrl,
  input  logic signed [31:0]  above,
  input  logic signed [31:0]  below,
  output logic signed [31:0]  data
);
  import see_pkg::*;

  logic signed [31:0] data_r;

  always_ff @(posedge clk) begin
    if (ctrl.shift_dn) begin
      data_r <= above;
    end else if (ctrl.shift_up) begin
      data_r <= below;
    end
  end

  assign data = data_r;

endmodule

FILE: hw/rtl/see_alu.sv
module see_alu #(
  parameter int FRACTION_BITS = see_pkg::SEE_FRACTION_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [2:0]         op,
  input  logic signed [31:0] left,
  input  logic signed [31:0] right,
  output logic               done,
  output logic signed [31:0] result
);
  import see_pkg::*;

  localparam int QW = 32;
  localparam int CW = $clog2(QW);

  see_alu_state_t     state_r, state_nxt;
  logic signed [31:0] res_r;
  logic signed [63:0] prod_r;
  logic [31:0]        absl_r, absr_r;
  logic               neg_r;
  logic               ovf_r;
  logic [31:0]        rem_r;
  logic [31:0]        quo_r;
  logic [CW-1:0]      cnt_r;

  logic signed [32:0] sum;
  logic signed [63:0] shifted;
  logic [63:0]        num;
  logic [63:0]        lim;
  logic [32:0]        trial;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? Q_MIN : Q_MAX;
    end
    return v[31:0];
  endfunction

  always_comb begin
    if (op == CMD_SUB) begin
      sum = 33'(left) - 33'(right);
    end else begin
      sum = 33'(left) + 33'(right);
    end
    shifted = prod_r >>> FRACTION_BITS;  // floor rounding
    num     = {32'b0, absl_r} << FRACTION_BITS;
    lim     = {32'b0, absr_r} << (QW - 1);
    trial   = {rem_r, quo_r[QW-1]} - {1'b0, absr_r};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ALU_IDLE: begin
        if (start) begin
          if (op == CMD_MUL) begin
            state_nxt = ALU_MUL;
          end else if (op == CMD_DIV) begin
            state_nxt = ALU_DIV_CHK;
          end else begin
            state_nxt = ALU_DONE;
          end
        end
      end
      ALU_MUL:     state_nxt = ALU_DONE;
      ALU_DIV_CHK: state_nxt = ALU_DIV_RUN;
      ALU_DIV_RUN: begin
        if (cnt_r == CW'(QW - 1)) begin
          state_nxt = ALU_DIV_FIX;
        end
      end
      ALU_DIV_FIX: state_nxt = ALU_DONE;
      ALU_DONE:    state_nxt = ALU_IDLE;
      default:     state_nxt = ALU_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done   = (state_r == ALU_DONE);
    result = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ALU_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ALU_IDLE: begin
        if (start) begin
          res_r  <= sat33(sum);
          prod_r <= 64'(left) * 64'(right);
          absl_r <= left[31]  ? (~left + 32'd1)  : left;
          absr_r <= right[31] ? (~right + 32'd1) : right;
          neg_r  <= left[31] ^ right[31];
        end
      end
      ALU_MUL: begin
        if ((&shifted[63:31]) || !(|shifted[63:31])) begin
          res_r <= shifted[31:0];
        end else begin
          res_r <= shifted[63] ? Q_MIN : Q_MAX;
        end
      end
      ALU_DIV_CHK: begin
        // quotient >= 2^31 saturates; otherwise high half stays below divisor
        ovf_r <= (num >= lim);
        rem_r <= num[63:32];
        quo_r <= num[31:0];
        cnt_r <= '0;
      end
      ALU_DIV_RUN: begin
        if (!trial[32]) begin
          rem_r <= trial[31:0];
          quo_r <= {quo_r[QW-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[30:0], quo_r[QW-1]};
          quo_r <= {quo_r[QW-2:0], 1'b0};
        end
        cnt_r <= cnt_r + CW'(1);
      end
      ALU_DIV_FIX: begin
        if (ovf_r) begin
          res_r <= neg_r ? Q_MIN : Q_MAX;
        end else begin
          res_r <= neg_r ? (~quo_r + 32'd1) : quo_r;
        end
      end
      ALU_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hw/rtl/stack_expression_evaluator_top.sv
// Postfix/prefix expression evaluator on signed fixed-point (Q16.16 default).
//
// Input channel (in_valid/in_stall/in_word): one token per word. Command push
// stacks operand_value; add/sub/mul/div pop two values and stack the result.
// A word is taken when in_valid is high and in_stall is low.
// Output channel (out_valid/out_stall/out_word): one word per token marked
// last_token, holding the top of stack and the first error seen (value zero
// on error). After that word is loaded the stack and status clear.
// cfg_wr_en/cfg_wr_data set operand order: 0 postfix (top is right operand),
// 1 prefix (top is left operand). Write it only while the block is idle.
//
// Stack is a row of shift cells, top in cell 0. One token at a time: a new
// word is taken only after the last one has passed through EXEC, WAIT for
// operators on the shared ALU (divide: one quotient bit per cycle), and FIN.
// A last token's result is loaded into the output register as FIN passes to
// IDLE, so it is there before the next accept.
// If the output register is still full and stalled, the block holds the
// finished token and stalls its input until the register frees up.
// Reset (rst_n low, synchronous) empties the stack, clears the status and
// the output valid, and sets postfix order. Stack contents are not reset.
module stack_expression_evaluator_top #(
  parameter int STACK_DEPTH   = see_pkg::SEE_STACK_DEPTH,
  parameter int FRACTION_BITS = see_pkg::SEE_FRACTION_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  see_pkg::see_in_t in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output see_pkg::see_out_t out_word,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data
);
  import see_pkg::*;

  localparam int SPW = $clog2(STACK_DEPTH + 1);

  see_state_t       state_r, state_nxt;
  see_in_t          tok_r;
  logic [SPW-1:0]   sp_r, sp_nxt;
  logic [2:0]       sticky_r, sticky_nxt;
  logic             order_r;
  logic             out_valid_r;
  see_out_t         out_word_r;

  logic signed [31:0] cell_q [STACK_DEPTH];
  see_shift_t         cell_ctrl [STACK_DEPTH];

  logic               push_en, pop_en, alu_start, alu_done, out_load, out_free;
  logic               is_op;
  logic signed [31:0] left, right, alu_res, top_in;
  see_out_t           fin_word;

  // operand selection from the two top cells
  always_comb begin
    left     = order_r ? cell_q[0] : cell_q[1];
    right    = order_r ? cell_q[1] : cell_q[0];
    is_op    = (tok_r.command >= CMD_ADD) && (tok_r.command <= CMD_DIV);
    out_free = !out_valid_r || !out_stall;
    top_in   = push_en ? tok_r.operand_value : alu_res;
  end

  // final word: status first, top of stack only when clean and non-empty
  always_comb begin
    fin_word.status       = sticky_r;
    fin_word.result_value = '0;
    if (sticky_r == ST_OK) begin
      if (sp_r == '0) begin
        fin_word.status = ST_EMPTY;
      end else begin
        fin_word.result_value = cell_q[0];
      end
    end
  end

  // control outputs
  always_comb begin
    in_stall   = 1'b1;
    push_en    = 1'b0;
    pop_en     = 1'b0;
    alu_start  = 1'b0;
    out_load   = 1'b0;
    sp_nxt     = sp_r;
    sticky_nxt = sticky_r;
    unique case (state_r)
      S_IDLE: in_stall = 1'b0;
      S_EXEC: begin
        if (sticky_r == ST_OK) begin
          if (tok_r.command == CMD_PUSH) begin
            if (sp_r >= SPW'(STACK_DEPTH)) begin
              sticky_nxt = ST_OVER;
            end else begin
              push_en = 1'b1;
              sp_nxt  = sp_r + SPW'(1);
            end
          end else if (is_op) begin
            if (sp_r < SPW'(2)) begin
              sticky_nxt = ST_UNDER;
            end else if ((tok_r.command == CMD_DIV) && (right == '0)) begin
              sticky_nxt = ST_DIV0;
            end else begin
              alu_start = 1'b1;
            end
          end
        end
      end
      S_WAIT: begin
        if (alu_done) begin
          pop_en = 1'b1;
          sp_nxt = sp_r - SPW'(1);
        end
      end
      S_FIN: begin
        if (tok_r.last_token && out_free) begin
          out_load   = 1'b1;
          sp_nxt     = '0;
          sticky_nxt = ST_OK;
        end
      end
      default: in_stall = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: state_nxt = alu_start ? S_WAIT : S_FIN;
      S_WAIT: begin
        if (alu_done) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!tok_r.last_token || out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      sticky_r    <= ST_OK;
      order_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      sp_r     <= sp_nxt;
      sticky_r <= sticky_nxt;
      if (cfg_wr_en) begin
        order_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && in_valid) begin
      tok_r <= in_word;
    end
    if (out_load) begin
      out_word_r <= fin_word;
    end
  end

  // stack cells: push shifts down, operator write-back shifts up under cell 0
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic signed [31:0] above, below;
    if (i == 0) begin : g_top
      assign above         = top_in;
      assign cell_ctrl[i]  = '{shift_dn: push_en | pop_en, shift_up: 1'b0};
    end else begin : g_rest
      assign above         = cell_q[i-1];
      assign cell_ctrl[i]  = '{shift_dn: push_en, shift_up: pop_en};
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = '0;
    end else begin : g_mid
      assign below = cell_q[i+1];
    end
    see_cell u_cell (
      .clk   (clk),
      .ctrl  (cell_ctrl[i]),
      .above (above),
      .below (below),
      .data  (cell_q[i])
    );
  end

  see_alu #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (alu_start),
    .op     (tok_r.command),
    .left   (left),
    .right  (right),
    .done   (alu_done),
    .result (alu_res)
  );

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_clear_after_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (sp_r == '0) && (sticky_r == ST_OK))
    else $error("stack not cleared after result");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_word_r.status != ST_OK)) |-> (out_word_r.result_value == '0))
    else $error("error result carries a value");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    alu_done |-> (state_r == S_WAIT))
    else $error("ALU finished outside of wait");

endmodule
